[rtl/ptdp_pkg.sv]
// Shared types and constants for the packed ternary dot product core.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package ptdp_pkg;

    // Trit codes packed two bits per lane in the weight byte
    localparam logic [1:0] CODE_PLUS  = 2'h1;
    localparam logic [1:0] CODE_MINUS = 2'h2;

    localparam int TRITS_PER_ITEM = 4;
    localparam int ACT_LANES      = 4;
    localparam int NUM_LANES      = (TRITS_PER_ITEM < ACT_LANES) ? TRITS_PER_ITEM : ACT_LANES;

    localparam int ACT_W   = 32;
    localparam int TERM_W  = ACT_W + 1;
    localparam int SUM_W   = TERM_W + $clog2(NUM_LANES + 1);
    localparam int ACC_W   = 64;
    localparam int LIMIT_W = 31;
    localparam int CNT_W   = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1073741823;

    typedef logic signed [ACT_W-1:0]  t_act;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Finished sum waiting for the clamp stage
    typedef struct packed {
        logic vld;
        t_acc sum;
    } t_fin;

endpackage

`default_nettype wire

[rtl/ptdp_lane.sv]
// One ternary lane: turns a trit code and an activation into a registered term.
// Depends on ptdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptdp_lane
    import ptdp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic [1:0] i_code,
    input  wire t_act       i_act,
    input  wire logic       i_count,
    output t_term           o_term
);

    t_term r_term;
    t_term n_term;

    // +a, -a or nothing; lanes masked off on the last transfer add nothing
    always_comb begin
        n_term = '0;
        if (i_count) begin
            if (i_code == CODE_PLUS) begin
                n_term = TERM_W'(i_act);
            end else if (i_code == CODE_MINUS) begin
                n_term = -TERM_W'(i_act);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

[rtl/ptdp_accum.sv]
// Merge stage: adds the lane terms into the 64-bit running sum and hands
// the final sum of a dot product to the clamp stage. Depends on ptdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptdp_accum
    import ptdp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_take,
    input  wire logic  i_last,
    input  wire t_term i_terms [NUM_LANES],
    input  wire logic  i_fin_pop,
    output t_fin       o_fin
);

    t_acc                    r_acc;
    t_acc                    r_fin_sum;
    logic                    r_fin_vld;
    logic signed [SUM_W-1:0] lane_sum;
    t_acc                    n_acc;

    // Adder tree over the lanes
    always_comb begin
        lane_sum = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            lane_sum = lane_sum + SUM_W'(i_terms[k]);
        end
        n_acc = r_acc + ACC_W'(lane_sum);
    end

    // Running sum, cleared once a dot product completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_take) begin
            r_acc <= i_last ? '0 : n_acc;
        end
    end

    // Final sum holding slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (i_take && i_last) begin
            r_fin_vld <= 1'b1;
        end else if (i_fin_pop) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_fin_sum <= n_acc;
        end
    end

    assign o_fin.vld = r_fin_vld;
    assign o_fin.sum = r_fin_sum;

    // A completed dot product leaves the running sum at zero
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_acc == '0))
        else $error("running sum not cleared after last transfer");

    // Only a last transfer raises the final slot
    a_fin_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fin_vld && !(i_take && i_last)) |=> !r_fin_vld)
        else $error("final slot filled without last transfer");

    // Never take a last transfer into an occupied slot that is not leaving
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |-> (!r_fin_vld || i_fin_pop))
        else $error("final slot overwritten");

endmodule

`default_nettype wire

[rtl/ptdp_clamp.sv]
// Output stage: clamps the final sum to +/- limit into the output register.
// Depends on ptdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptdp_clamp
    import ptdp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_fin               i_fin,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output logic                    o_fin_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_act                    o_dot_value
);

    logic r_out_vld;
    t_act r_out_val;
    t_acc lim;
    t_acc neg_lim;
    t_acc n_clamped;
    logic out_free;

    // Symmetric saturation
    always_comb begin
        lim     = $signed({{(ACC_W - LIMIT_W){1'b0}}, i_limit});
        neg_lim = -lim;
        priority if (i_fin.sum > lim) begin
            n_clamped = lim;
        end else if (i_fin.sum < neg_lim) begin
            n_clamped = neg_lim;
        end else begin
            n_clamped = i_fin.sum;
        end
    end

    assign out_free  = !r_out_vld || i_out_ready;
    assign o_fin_pop = i_fin.vld && out_free;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= i_fin.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_pop) begin
            r_out_val <= n_clamped[ACT_W-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_dot_value = r_out_val;

    // Clamp range never reaches the most negative 32-bit value
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_val != {1'b1, {(ACT_W - 1){1'b0}}}))
        else $error("output outside clamp range");

endmodule

`default_nettype wire

[rtl/packed_ternary_dot_product_core.sv]
// Packed ternary dot product core. A last transfer's result passes the lane register
// (loaded at acceptance), then the final slot, then the output register.
// Throughput: one item per cycle, set by the 64-bit accumulate loop; the input stalls
// only when a last item meets a full final slot and an output register not ready.
// Reset (i_rst_n, synchronous, active low) clears the running sum, all valid
// flags and sets the clamp limit to 1073741823. Depends on ptdp_pkg and submodules.
`timescale 1ns / 1ps
`default_nettype none

module packed_ternary_dot_product_core
    import ptdp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_weight_byte,
    input  wire t_act               i_act_lane0,
    input  wire t_act               i_act_lane1,
    input  wire t_act               i_act_lane2,
    input  wire t_act               i_act_lane3,
    input  wire logic [CNT_W-1:0]   i_valid_trits,
    input  wire logic               i_last_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_act                    o_dot_value
);

    logic [LIMIT_W-1:0] r_clamp_limit;
    logic               r_lane_vld;
    logic               r_lane_last;
    t_act               acts [ACT_LANES];
    t_term              terms [NUM_LANES];
    t_fin               fin;
    logic               fin_pop;
    logic               fin_free;
    logic               merge_take;
    logic               in_xfer;

    assign acts[0] = i_act_lane0;
    assign acts[1] = i_act_lane1;
    assign acts[2] = i_act_lane2;
    assign acts[3] = i_act_lane3;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_clamp_limit <= i_cfg_wdata;
        end
    end

    // Pipeline flow control
    assign fin_free   = !fin.vld || fin_pop;
    assign merge_take = r_lane_vld && (!r_lane_last || fin_free);
    assign o_in_ready = !r_lane_vld || merge_take;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_lane_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lane_last <= i_last_item;
        end
    end

    // Lane array
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        ptdp_lane u_lane (
            .i_clk   (i_clk),
            .i_load  (in_xfer),
            .i_code  (i_weight_byte[2*k +: 2]),
            .i_act   (acts[k]),
            .i_count (!i_last_item || (i_valid_trits > CNT_W'(k))),
            .o_term  (terms[k])
        );
    end

    ptdp_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (merge_take),
        .i_last    (r_lane_last),
        .i_terms   (terms),
        .i_fin_pop (fin_pop),
        .o_fin     (fin)
    );

    ptdp_clamp u_clamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin       (fin),
        .i_limit     (r_clamp_limit),
        .o_fin_pop   (fin_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dot_value (o_dot_value)
    );

    // Stall only when the lane stage holds work that cannot move
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_lane_vld && r_lane_last && fin.vld))
        else $error("input stalled without blocked last transfer");

    // An accepted transfer occupies the lane stage next cycle
    a_lane_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_lane_vld)
        else $error("accepted transfer lost");

endmodule

`default_nettype wire
